### design/wss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types and constants for the wavefront sum stencil.
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam int MAX_Y_DEF   = 64;
  localparam int MAX_Z_DEF   = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int SIZE_X_W = 16;
  localparam int SIZE_Y_W = 7;
  localparam int SIZE_Z_W = 7;

  localparam logic [SIZE_X_W-1:0] SIZE_X_RST = 16'd16;
  localparam logic [SIZE_Y_W-1:0] SIZE_Y_RST = 7'd16;
  localparam logic [SIZE_Z_W-1:0] SIZE_Z_RST = 7'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_t;

  // One classified cell on its way from the front to the back
  typedef struct packed {
    logic signed [31:0] cur;
    logic signed [31:0] prev;
    logic               pass;
    logic               last;
  } cell_t;

  // Back-end occupancy, seen by the top level
  typedef struct packed {
    logic stage_valid;
    logic out_valid;
  } bk_stat_t;

endpackage

### design/wss_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_if
// Valid/ready channels for input cells and result cells.
// ----------------------------------------------------------------------------
interface wss_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cur_value;
  logic signed [31:0] prev_slab_value;

  modport source (output valid, output cur_value, output prev_slab_value, input ready);
  modport sink   (input valid, input cur_value, input prev_slab_value, output ready);
endinterface

interface wss_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_value;
  logic               last_in_slab;

  modport source (output valid, output new_value, output last_in_slab, input ready);
  modport sink   (input valid, input new_value, input last_in_slab, output ready);
endinterface

### design/wss_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_queue
// Small register FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module wss_queue #(
  parameter int W     = 8,
  parameter int DEPTH = wss_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### design/wss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_front
// Size registers, raster counters and per-cell classification.
// ----------------------------------------------------------------------------
module wss_front #(
  parameter int MAX_Y = wss_pkg::MAX_Y_DEF,
  parameter int MAX_Z = wss_pkg::MAX_Z_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  wss_in_if.sink                          cells_in,
  input  logic                            cfg_we,
  input  logic [wss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wss_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            q_full,
  output logic                            push,
  output wss_pkg::cell_t                  classified,
  output logic [$clog2(MAX_Y*MAX_Z)-1:0]  idx
);

  localparam int AW  = $clog2(MAX_Y * MAX_Z);
  localparam int XW  = wss_pkg::SIZE_X_W;
  localparam int YW  = $clog2(MAX_Y);
  localparam int ZW  = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int YCW = ((YW > wss_pkg::SIZE_Y_W) ? YW : wss_pkg::SIZE_Y_W) + 1;
  localparam int ZCW = ((ZW > wss_pkg::SIZE_Z_W) ? ZW : wss_pkg::SIZE_Z_W) + 1;
  localparam int XCW = wss_pkg::SIZE_X_W + 1;

  logic [wss_pkg::SIZE_X_W-1:0] size_x;
  logic [wss_pkg::SIZE_Y_W-1:0] size_y;
  logic [wss_pkg::SIZE_Z_W-1:0] size_z;

  logic [wss_pkg::SIZE_X_W-1:0] x_count, x_count_next;
  logic [YW-1:0]                y_count, y_count_next;
  logic [ZW-1:0]                z_count, z_count_next;

  logic [XCW-1:0] sx_eff;
  logic [YCW-1:0] sy_eff;
  logic [ZCW-1:0] sz_eff;
  logic           x_end, y_end, z_end;

  // Zero acts as one; oversize clamps to the store dimension
  always_comb begin
    sx_eff = (size_x == '0) ? XCW'(1) : XCW'(size_x);
    if (size_y == '0) begin
      sy_eff = YCW'(1);
    end else if (YCW'(size_y) > YCW'(MAX_Y)) begin
      sy_eff = YCW'(MAX_Y);
    end else begin
      sy_eff = YCW'(size_y);
    end
    if (size_z == '0) begin
      sz_eff = ZCW'(1);
    end else if (ZCW'(size_z) > ZCW'(MAX_Z)) begin
      sz_eff = ZCW'(MAX_Z);
    end else begin
      sz_eff = ZCW'(size_z);
    end
  end

  always_comb begin
    z_end = (ZCW'(z_count) + ZCW'(1)) >= sz_eff;
    y_end = (YCW'(y_count) + YCW'(1)) >= sy_eff;
    x_end = (XCW'(x_count) + XCW'(1)) >= sx_eff;

    x_count_next = x_count;
    y_count_next = y_count;
    z_count_next = z_count;
    if (!z_end) begin
      z_count_next = z_count + ZW'(1);
    end else begin
      z_count_next = '0;
      if (!y_end) begin
        y_count_next = y_count + YW'(1);
      end else begin
        y_count_next = '0;
        x_count_next = x_end ? '0 : x_count + XW'(1);
      end
    end
  end

  assign cells_in.ready = !q_full;
  assign push           = cells_in.valid && !q_full;

  always_comb begin
    classified.cur  = cells_in.cur_value;
    classified.prev = cells_in.prev_slab_value;
    classified.pass = (x_count == '0) || (y_count == '0);
    classified.last = z_end && y_end && x_end;
    idx             = AW'(y_count) * AW'(MAX_Z) + AW'(z_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= wss_pkg::SIZE_X_RST;
      size_y <= wss_pkg::SIZE_Y_RST;
      size_z <= wss_pkg::SIZE_Z_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wss_pkg::REG_SIZE_X: size_x <= cfg_data;
        wss_pkg::REG_SIZE_Y: size_y <= cfg_data[wss_pkg::SIZE_Y_W-1:0];
        wss_pkg::REG_SIZE_Z: size_z <= cfg_data[wss_pkg::SIZE_Z_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_count <= '0;
      y_count <= '0;
      z_count <= '0;
    end else if (push) begin
      x_count <= x_count_next;
      y_count <= y_count_next;
      z_count <= z_count_next;
    end
  end

endmodule

### design/wss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wss_back
// Plane store, neighbour sum and result register.
// ----------------------------------------------------------------------------
module wss_back #(
  parameter int MAX_Y = wss_pkg::MAX_Y_DEF,
  parameter int MAX_Z = wss_pkg::MAX_Z_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  wss_pkg::cell_t                 q_cell,
  input  logic [$clog2(MAX_Y*MAX_Z)-1:0] q_idx,
  output logic                           q_pop,
  wss_out_if.source                      cells_out,
  output wss_pkg::bk_stat_t              stat
);

  localparam int AW    = $clog2(MAX_Y * MAX_Z);
  localparam int DEPTH = MAX_Y * MAX_Z;

  logic [31:0] plane_mem [DEPTH];

  logic               e_valid;
  wss_pkg::cell_t     e_cell;
  logic [AW-1:0]      e_idx;
  logic [AW-1:0]      e_up_idx;
  logic [31:0]        left_q, up_q;
  logic               fw_valid;
  logic [AW-1:0]      fw_addr;
  logic [31:0]        fw_data;

  logic               o_valid;
  logic signed [31:0] o_value;
  logic               o_last;

  logic               e_leave, advance;
  logic [AW-1:0]      q_up_idx;
  logic [31:0]        left_v, up_v, e_sum;

  assign e_leave  = e_valid && (!o_valid || cells_out.ready);
  assign advance  = q_valid && (!e_valid || e_leave);
  assign q_pop    = advance;
  assign q_up_idx = q_idx - AW'(MAX_Z);
  assign e_up_idx = e_idx - AW'(MAX_Z);

  // The write of the item leaving at the read edge is not yet in the store
  always_comb begin
    left_v = (fw_valid && fw_addr == e_idx)    ? fw_data : left_q;
    up_v   = (fw_valid && fw_addr == e_up_idx) ? fw_data : up_q;
    e_sum  = e_cell.pass ? e_cell.cur : e_cell.cur + left_v + up_v + e_cell.prev;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      left_q <= plane_mem[q_idx];
      up_q   <= plane_mem[q_up_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (e_leave) begin
      plane_mem[e_idx] <= e_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      e_cell  <= q_cell;
      e_idx   <= q_idx;
      fw_addr <= e_idx;
      fw_data <= e_sum;
    end
    if (e_leave) begin
      o_value <= e_sum;
      o_last  <= e_cell.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid  <= 1'b0;
      fw_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (advance) begin
        e_valid  <= 1'b1;
        fw_valid <= e_leave;
      end else if (e_leave) begin
        e_valid <= 1'b0;
      end
      if (e_leave) begin
        o_valid <= 1'b1;
      end else if (cells_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  assign cells_out.valid        = o_valid;
  assign cells_out.new_value    = o_value;
  assign cells_out.last_in_slab = o_last;

  assign stat.stage_valid = e_valid;
  assign stat.out_valid   = o_valid;

endmodule

### design/wavefront_sum_stencil.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavefront_sum_stencil
// One slab of a 3D grid, one cell per beat, with a wavefront neighbour sum.
// ----------------------------------------------------------------------------
// Cells arrive in raster order (x outer, y, z inner) and one result beat
// leaves for each input beat, in order. Throughput is one cell per clock
// while the sink is ready: the plane store is read at two addresses (own
// entry, left neighbour; the entry one row up) and written at one address
// per result, and the single four-operand add sits between the registered
// read data and the result register. Beats pass the queue, sum stage and
// result register. Cells on the x = 0 plane or the y = 0 row pass through
// unchanged; the store needs no clearing after reset, so the block takes
// cells from the first cycle out of reset. The store holds MAX_Y * MAX_Z
// words; size_y and size_z above those limits are clamped, and a size of
// zero acts as one. Write the size registers only while no cell is in
// flight; the position counters keep their place across such writes.
// ----------------------------------------------------------------------------
module wavefront_sum_stencil #(
  parameter int MAX_Y = wss_pkg::MAX_Y_DEF,
  parameter int MAX_Z = wss_pkg::MAX_Z_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  wss_in_if.sink                         cells_in,
  wss_out_if.source                      cells_out,
  input  logic                           cfg_we,
  input  logic [wss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wss_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_Y * MAX_Z);
  localparam int QW = $bits(wss_pkg::cell_t) + AW;

  // Front to queue
  logic              push;
  wss_pkg::cell_t    f_cell;
  logic [AW-1:0]     f_idx;
  logic              q_full;

  // Queue to back
  logic              q_valid;
  logic              q_pop;
  logic [QW-1:0]     q_head;
  wss_pkg::cell_t    q_cell;
  logic [AW-1:0]     q_idx;

  wss_pkg::bk_stat_t bk_stat;

  // Classify each cell and track its raster position
  wss_front #(
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cells_in   (cells_in),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .classified (f_cell),
    .idx        (f_idx)
  );

  // Decouple acceptance from the back end's stalls
  wss_queue #(
    .W     (QW),
    .DEPTH (wss_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({f_cell, f_idx}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  assign q_cell = wss_pkg::cell_t'(q_head[QW-1:AW]);
  assign q_idx  = q_head[AW-1:0];

  // Read neighbours, add, write back and hold the result beat
  wss_back #(
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cell    (q_cell),
    .q_idx     (q_idx),
    .q_pop     (q_pop),
    .cells_out (cells_out),
    .stat      (bk_stat)
  );

`ifndef SYNTHESIS
  // Drain only from a queue that holds a beat
  a_pop_has_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // An empty sum stage always takes a waiting beat
  a_stage_fills: assert property (@(posedge clk) disable iff (rst)
    q_valid && !bk_stat.stage_valid |=> bk_stat.stage_valid)
    else $error("sum stage left empty with a beat waiting");

  // Reset leaves no beat anywhere in the pipeline
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !q_valid && !bk_stat.stage_valid && !bk_stat.out_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule
